// ----- rtl/osd_ahr_pkg.sv -----
// ----------------------------------------------------------------------------
// osd_ahr_pkg: shared types and constants of the artificial horizon renderer
// Field widths, register codes, the token and write-slot structs passed along
// the cell row, and the reversal helper.
// ----------------------------------------------------------------------------
package osd_ahr_pkg;

    localparam int HALF_WIDTH_DEF = 8;      // columns on each side of center
    localparam int MAX_WRITES     = 32;     // writes issued per frame at most

    localparam int ANGLE_W    = 9;          // roll / pitch in whole degrees
    localparam int H_W        = 14;         // raw line height, signed
    localparam int MAG_W      = 13;         // magnitude of the raw height
    localparam int RECIP_W    = 15;         // width of the reciprocal factor
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam int QUOT_W     = 11;         // floor(2*|h|/15): row and sub-row
    localparam int SUB_W      = 4;          // sub-row glyph index
    localparam int HT_W       = 8;          // signed row height
    localparam int LAST_W     = 5;          // stored height, saturated
    localparam int ROW_W      = 4;
    localparam int COL_W      = 5;
    localparam int GLYPH_W    = 8;
    localparam int SPACING_W  = 3;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // h = roll*i - pitch*16 + 60; the row is h/120, the sub-row 16ths of it.
    // floor(2*a/15) carries both: row in the upper bits, sub-row in the low four.
    localparam int H_OFFSET     = 60;
    localparam int PITCH_SHIFT  = 4;
    localparam int RECIP_MUL    = 17477;    // ceil(2^17 * 2 / 15)
    localparam int RECIP_SHIFT  = 17;
    localparam int ROW_BIAS     = 3;
    localparam int COL_CENTER   = 15;

    localparam logic [GLYPH_W-1:0]   GLYPH_LINE  = 8'hC0;
    localparam logic [GLYPH_W-1:0]   GLYPH_BLANK = 8'h00;
    localparam logic [SPACING_W-1:0] SPACING_RST = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_SPACING = 2'd0,
        REG_CENTER_DOT  = 2'd1,
        REG_ROLL_REV    = 2'd2,
        REG_PITCH_REV   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [SPACING_W-1:0] row_spacing;
        logic                 center_dot;
    } cfg_t;

    // frame token travelling down the cell row
    typedef struct packed {
        logic                      valid;
        logic signed [H_W-1:0]     h;
        logic signed [ANGLE_W-1:0] roll;
    } tok_t;

    // one pending display write
    typedef struct packed {
        logic               valid;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [GLYPH_W-1:0] glyph;
    } slot_t;

    // negate, with minus 256 saturating to 255
    function automatic logic signed [ANGLE_W-1:0] neg_sat(
        input logic signed [ANGLE_W-1:0] v);
        logic signed [ANGLE_W-1:0] r;
        if (v == {1'b1, {(ANGLE_W-1){1'b0}}}) begin
            r = {1'b0, {(ANGLE_W-1){1'b1}}};
        end else begin
            r = -v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/osd_ahr_cell.sv -----
// ----------------------------------------------------------------------------
// osd_ahr_cell: one column of the horizon
// Takes the frame token, derives row and sub-row of its column, keeps the
// row drawn last frame, and holds two write slots of the drain chain.
// ----------------------------------------------------------------------------
module osd_ahr_cell import osd_ahr_pkg::*; #(
    parameter int HALF_WIDTH = HALF_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  tok_t       tok_in,
    output tok_t       tok_out,
    output logic       done,
    input  logic       load,
    input  logic       shift,
    input  slot_t      slot_next,
    output slot_t      slot_head,
    output logic [1:0] slot_valid
);

    localparam logic [COL_W-1:0] COLUMN = COL_W'(COL_CENTER - HALF_WIDTH + INDEX);
    localparam logic IS_DOT = (INDEX == HALF_WIDTH - 1) || (INDEX == HALF_WIDTH);
    localparam logic signed [HT_W-1:0] LAST_MAX = HT_W'(2 ** (LAST_W - 1) - 1);
    localparam logic signed [HT_W-1:0] LAST_MIN = -LAST_MAX - HT_W'(1);

    logic                      tok_v_reg;
    logic signed [H_W-1:0]     h_reg;
    logic signed [ANGLE_W-1:0] roll_reg;
    logic                      prod_v_reg;
    logic [QUOT_W-1:0]         t_reg, t_next;
    logic                      neg_reg;
    logic                      done_reg;
    slot_t                     draw_reg, draw_next;
    slot_t                     blank_reg, blank_next;
    logic signed [LAST_W-1:0]  last_reg, last_next;
    slot_t                     slot0_reg, slot1_reg;

    logic [MAG_W-1:0]          mag;
    logic [PROD_W-1:0]         prod;
    logic [QUOT_W-SUB_W-1:0]   qa;
    logic [SUB_W-1:0]          sub;
    logic signed [HT_W-1:0]    ht, last_x, band;
    logic                      ht_in, last_in, dot;

    // hand the token on, one column further right
    assign tok_out.valid = tok_v_reg;
    assign tok_out.h     = h_reg + H_W'(roll_reg);
    assign tok_out.roll  = roll_reg;

    // |h| times the reciprocal of 7.5
    assign mag    = h_reg[H_W-1] ? MAG_W'(-h_reg) : MAG_W'(h_reg);
    assign prod   = PROD_W'(mag) * PROD_W'(RECIP_MUL);
    assign t_next = prod[RECIP_SHIFT +: QUOT_W];

    // truncating division, then one step down for a negative height
    always_comb begin
        qa     = t_reg[QUOT_W-1:SUB_W];
        ht     = neg_reg ? $signed(~{1'b0, qa}) : $signed({1'b0, qa});
        sub    = neg_reg ? ~t_reg[SUB_W-1:0] : t_reg[SUB_W-1:0];
        band   = $signed({{(HT_W-SPACING_W){1'b0}}, cfg.row_spacing});
        last_x = {{(HT_W-LAST_W){last_reg[LAST_W-1]}}, last_reg};
        ht_in  = (ht >= -band) && (ht <= band);
        last_in = (last_x >= -band) && (last_x <= band);
        dot    = cfg.center_dot && IS_DOT;

        draw_next.valid  = !(dot && ht == '0) && ht_in;
        draw_next.row    = {1'b0, cfg.row_spacing} + ROW_W'(ROW_BIAS) - ht[ROW_W-1:0];
        draw_next.column = COLUMN;
        draw_next.glyph  = GLYPH_LINE + GLYPH_W'(sub);

        blank_next.valid  = !(dot && last_x == '0) && (ht != last_x) && last_in;
        blank_next.row    = {1'b0, cfg.row_spacing} + ROW_W'(ROW_BIAS)
                            - last_x[ROW_W-1:0];
        blank_next.column = COLUMN;
        blank_next.glyph  = GLYPH_BLANK;

        // anything beyond the widest band only has to compare unequal
        if (ht > LAST_MAX) begin
            last_next = LAST_MAX[LAST_W-1:0];
        end else if (ht < LAST_MIN) begin
            last_next = LAST_MIN[LAST_W-1:0];
        end else begin
            last_next = ht[LAST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            done_reg   <= 1'b0;
            last_reg   <= '0;      // a zero pair puts every column on row zero
            slot0_reg  <= '0;
            slot1_reg  <= '0;
        end else begin
            tok_v_reg  <= tok_in.valid;
            prod_v_reg <= tok_v_reg;
            done_reg   <= prod_v_reg;
            if (prod_v_reg) begin
                last_reg <= last_next;
            end
            if (load) begin
                slot0_reg <= draw_reg;
                slot1_reg <= blank_reg;
            end else if (shift) begin
                slot0_reg <= slot1_reg;
                slot1_reg <= slot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_in.valid) begin
            h_reg    <= tok_in.h;
            roll_reg <= tok_in.roll;
        end
        if (tok_v_reg) begin
            t_reg   <= t_next;
            neg_reg <= h_reg[H_W-1];
        end
        if (prod_v_reg) begin
            draw_reg  <= draw_next;
            blank_reg <= blank_next;
        end
    end

    assign done       = done_reg;
    assign slot_head  = slot0_reg;
    assign slot_valid = {slot1_reg.valid, slot0_reg.valid};

endmodule

// ----- rtl/osd_ahr_out.sv -----
// ----------------------------------------------------------------------------
// osd_ahr_out: output register of the write stream
// Takes the head slot of the drain chain, caps the writes of a frame and
// marks the final one.
// ----------------------------------------------------------------------------
module osd_ahr_out import osd_ahr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 frame_start,
    input  logic                 chain_busy,
    input  slot_t                head,
    input  logic                 rest_any,
    output logic                 advance,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int CNT_W = $clog2(MAX_WRITES + 1);

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 can_take, issue, is_final;

    assign can_take   = !m_valid_reg || m_tready;
    assign advance    = chain_busy && can_take;
    assign issue      = advance && head.valid && (count_reg < CNT_W'(MAX_WRITES));
    assign is_final   = !rest_any || (count_reg == CNT_W'(MAX_WRITES - 1));
    assign count_next = count_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            if (frame_start) begin
                count_reg <= '0;
            end else if (issue) begin
                count_reg <= count_next;
            end
            if (issue) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            m_data_reg <= M_TDATA_W'({head.glyph, head.column, head.row});
            m_last_reg <= is_final;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/osd_artificial_horizon_renderer.sv -----
// ----------------------------------------------------------------------------
// osd_artificial_horizon_renderer: horizon line writes for a character OSD
// One roll/pitch item per frame becomes a run of character writes: a line
// glyph where the horizon crosses each column, a blank where it was before.
//
//   channel   direction  payload (low bit first)                 marker
//   s_*       in         roll_degrees[8:0], pitch_degrees[17:9]   -
//   m_*       out        screen_row[3:0], screen_column[8:4],     tlast =
//                        glyph_code[16:9]                         final_write
//   cfg_*     in         index 0..3, data[2:0]                    -
//
// Flow: an item waits in the pending register until the last results have
// loaded; its token then walks the 2*HALF_WIDTH column cells at one cell a
// cycle, each cell finishing once its quotient and result registers follow.
// Results load into a drain chain of 4*HALF_WIDTH slots, which shifts one
// slot a cycle unless the output stalls, ending at its last valid write.
// The next item is accepted while the chain drains; its walk overlaps.
// Reset: registers to defaults, every stored column height to row zero.
// Stalls: a held write with m_tready low freezes the drain chain, not the walk.
// ----------------------------------------------------------------------------
module osd_artificial_horizon_renderer import osd_ahr_pkg::*; #(
    parameter int HALF_WIDTH = HALF_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // roll_degrees [8:0], pitch_degrees [17:9]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // screen_row [3:0], screen_column [8:4], glyph_code [16:9]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int NCELL = 2 * HALF_WIDTH;
    localparam logic signed [H_W-1:0] HW_S  = H_W'(HALF_WIDTH);
    localparam logic signed [H_W-1:0] H_OFS = H_W'(H_OFFSET);

    // configuration registers
    logic [SPACING_W-1:0] row_spacing_reg;
    logic                 center_dot_reg;
    logic                 roll_rev_reg;
    logic                 pitch_rev_reg;
    cfg_t                 cfg;

    // pending item and frame control
    logic                      pend_v_reg;
    logic signed [ANGLE_W-1:0] pend_roll_reg, pend_pitch_reg;
    logic signed [ANGLE_W-1:0] roll_in, pitch_in, roll_use, pitch_use;
    logic                      wave_busy_reg;
    logic                      res_ready_reg;
    logic                      s_accept, launch, load;
    logic signed [H_W-1:0]     h_start;

    // cell row
    tok_t                tok_chain  [0:NCELL];
    slot_t               slot_chain [0:NCELL];
    logic [NCELL-1:0]    done_vec;
    logic [2*NCELL-1:0]  slot_valid;
    logic                chain_busy, rest_any, advance;

    assign cfg.row_spacing = row_spacing_reg;
    assign cfg.center_dot  = center_dot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_spacing_reg <= SPACING_RST;
            center_dot_reg  <= 1'b1;
            roll_rev_reg    <= 1'b0;
            pitch_rev_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_SPACING: row_spacing_reg <= cfg_wdata;
                REG_CENTER_DOT:  center_dot_reg  <= cfg_wdata[0];
                REG_ROLL_REV:    roll_rev_reg    <= cfg_wdata[0];
                REG_PITCH_REV:   pitch_rev_reg   <= cfg_wdata[0];
            endcase
        end
    end

    // apply the reversal on the way in; the reversed pair is what the
    // cells remember as last frame's horizon
    assign roll_in   = $signed(s_tdata[ANGLE_W-1:0]);
    assign pitch_in  = $signed(s_tdata[2*ANGLE_W-1:ANGLE_W]);
    assign roll_use  = roll_rev_reg  ? neg_sat(roll_in)  : roll_in;
    assign pitch_use = pitch_rev_reg ? neg_sat(pitch_in) : pitch_in;

    assign s_tready = !pend_v_reg;
    assign s_accept = s_tvalid && s_tready;

    // launch a token once the previous frame has left the cells' result
    // registers; load the drain chain once it has run dry
    assign launch = pend_v_reg && !wave_busy_reg;
    assign load   = res_ready_reg && !chain_busy;

    // height at the leftmost column: 60 - 16*pitch - HALF_WIDTH*roll
    assign h_start = H_OFS - (H_W'(pend_pitch_reg) <<< PITCH_SHIFT)
                     - H_W'(pend_roll_reg) * HW_S;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg    <= 1'b0;
            wave_busy_reg <= 1'b0;
            res_ready_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                pend_v_reg <= 1'b1;
            end else if (launch) begin
                pend_v_reg <= 1'b0;
            end
            if (launch) begin
                wave_busy_reg <= 1'b1;
            end else if (load) begin
                wave_busy_reg <= 1'b0;
            end
            if (done_vec[NCELL-1]) begin
                res_ready_reg <= 1'b1;
            end else if (load) begin
                res_ready_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_roll_reg  <= roll_use;
            pend_pitch_reg <= pitch_use;
        end
    end

    // token enters at the leftmost column; nothing follows the last slot
    assign tok_chain[0].valid = launch;
    assign tok_chain[0].h     = h_start;
    assign tok_chain[0].roll  = pend_roll_reg;
    assign slot_chain[NCELL]  = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        osd_ahr_cell #(
            .HALF_WIDTH (HALF_WIDTH),
            .INDEX      (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cfg        (cfg),
            .tok_in     (tok_chain[k]),
            .tok_out    (tok_chain[k+1]),
            .done       (done_vec[k]),
            .load       (load),
            .shift      (advance),
            .slot_next  (slot_chain[k+1]),
            .slot_head  (slot_chain[k]),
            .slot_valid (slot_valid[2*k +: 2])
        );
    end

    // head is final when nothing valid stands behind it
    assign chain_busy = |slot_valid;
    assign rest_any   = |slot_valid[2*NCELL-1:1];

    osd_ahr_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_start (load),
        .chain_busy  (chain_busy),
        .head        (slot_chain[0]),
        .rest_any    (rest_any),
        .advance     (advance),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // only one frame walks the row, so no launch over unloaded results
    a_launch_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        launch |-> !res_ready_reg)
        else $error("token launched over results not yet loaded");

    a_one_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(done_vec))
        else $error("two cells finished in the same cycle");

    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_chain[NCELL].valid |-> ##2 done_vec[NCELL-1])
        else $error("last cell did not finish after the token passed");

    a_done_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        done_vec[NCELL-1] |-> wave_busy_reg && !res_ready_reg)
        else $error("last cell finished outside a frame walk");

endmodule
